// ===== rtl/gmc_pkg.sv =====
// Shared types, widths and register codes for the gain and magnitude clipper.
// Used by gmc_ctrl, gmc_dp, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package gmc_pkg;

	// default sample and gain format
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 12;

	// fixed register and result widths
	localparam int GAIN_W    = 16;
	localparam int CEIL_W    = 15;
	localparam int ACC_W     = 44;
	localparam int PEAK_W    = 32;
	localparam int CNT_W     = 48;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd4096;
	localparam logic [CEIL_W-1:0] CEIL_RESET    = 15'h7fff;
	localparam logic              CLIP_EN_RESET = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN    = 2'd0,
		REG_CEILING = 2'd1,
		REG_CLIP_EN = 2'd2
	} gmc_reg_t;

	// width of a scaled sample magnitude after rounding
	function automatic int smag_width(input int w, input int f);
		return w + GAIN_W + 1 - f;
	endfunction

	// width of the square root of a scaled squared magnitude
	function automatic int root_width(input int w, input int f);
		return smag_width(w, f) + 1;
	endfunction

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic scale;
		logic square;
		logic mag;
		logic decide;
		logic sqrt_init;
		logic sqrt_step;
		logic round;
		logic prod;
		logic div_load;
		logic div_sel;
		logic div_step;
		logic div_keep;
		logic finish;
	} gmc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clip_hit;
		logic out_free;
	} gmc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/gmc_ctrl.sv =====
// Sequencer for the gain and magnitude clipper: steps one sample word
// through scale, magnitude test, square root and division. Uses gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_ctrl #(
	parameter int SAMPLE_WIDTH   = gmc_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = gmc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire gmc_pkg::gmc_sts_t sts,
	output gmc_pkg::gmc_cmd_t     cmd
);
	import gmc_pkg::*;

	localparam int RT_W     = root_width(SAMPLE_WIDTH, GAIN_FRAC_BITS);
	localparam int STEP_MAX = (RT_W > CEIL_W) ? RT_W : CEIL_W;
	localparam int CNT_BITS = $clog2(STEP_MAX);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_SQUARE,
		S_MAG,
		S_DECIDE,
		S_SQRT,
		S_ROUND,
		S_LOAD_I,
		S_DIV_I,
		S_LOAD_Q,
		S_DIV_Q,
		S_DONE
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic                sqrt_last;
	logic                div_last;

	assign sqrt_last = (cnt_q == CNT_BITS'(RT_W - 1));
	assign div_last  = (cnt_q == CNT_BITS'(CEIL_W - 1));

	// one word in flight; new words only in idle
	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_SQUARE;
			end
			S_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = S_MAG;
			end
			S_MAG: begin
				cmd.mag = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide    = 1'b1;
				cmd.sqrt_init = 1'b1;
				cmd.prod      = 1'b1;
				cnt_d         = '0;
				state_d       = sts.clip_hit ? S_SQRT : S_DONE;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (sqrt_last) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_LOAD_I;
			end
			S_LOAD_I: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = 1'b0;
				cnt_d        = '0;
				state_d      = S_DIV_I;
			end
			S_DIV_I: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (div_last) begin
					state_d = S_LOAD_Q;
				end
			end
			S_LOAD_Q: begin
				cmd.div_keep = 1'b1;
				cmd.div_load = 1'b1;
				cmd.div_sel  = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV_Q;
			end
			S_DIV_Q: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gmc_dp.sv =====
// Datapath of the gain and magnitude clipper: config registers, scaling,
// bit-serial square root, shared divider, block metrics and output register.
// Driven by gmc_ctrl commands; uses gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmc_dp #(
	parameter int SAMPLE_WIDTH   = gmc_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = gmc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [gmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gmc_pkg::GAIN_W-1:0]        cfg_data,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_q,
	input  wire logic                              block_end,
	input  wire logic                              out_stall,
	input  wire gmc_pkg::gmc_cmd_t                 cmd,
	output gmc_pkg::gmc_sts_t                      sts,
	output logic                                   out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]         out_i,
	output logic signed [SAMPLE_WIDTH-1:0]         out_q,
	output logic                                   was_clipped,
	output logic                                   last_out,
	output logic [gmc_pkg::ACC_W-1:0]              block_power_sum,
	output logic [gmc_pkg::PEAK_W-1:0]             block_peak_power,
	output logic [gmc_pkg::CNT_W-1:0]              total_clipped,
	output logic [gmc_pkg::CNT_W-1:0]              total_processed
);
	import gmc_pkg::*;

	localparam int W       = SAMPLE_WIDTH;
	localparam int F       = GAIN_FRAC_BITS;
	localparam int SPROD_W = W + GAIN_W + 1;
	localparam int SMAG_W  = smag_width(W, F);
	localparam int SQ_W    = 2 * SMAG_W;
	localparam int M2_W    = SQ_W + 1;
	localparam int CSQ_W   = 2 * CEIL_W;
	localparam int CMP_W   = (M2_W > CSQ_W) ? M2_W : CSQ_W;
	localparam int RT_W    = root_width(W, F);
	localparam int N_W     = 2 * RT_W;
	localparam int SR_W    = RT_W + 2;
	localparam int D_W     = RT_W + 1;
	localparam int NUM_W   = SMAG_W + CEIL_W;
	localparam int P_W     = 2 * W;
	localparam int SUM_W   = ((ACC_W > P_W) ? ACC_W : P_W) + 1;
	localparam int OM_W    = (SMAG_W > CEIL_W) ? SMAG_W : CEIL_W;

	localparam logic [SPROD_W-1:0] ROUND_HALF = SPROD_W'(1) << (F - 1);
	localparam logic [ACC_W-1:0]   ACC_MAX    = '1;
	localparam logic [PEAK_W-1:0]  PEAK_MAX   = '1;
	localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
	localparam logic [OM_W-1:0]    POS_LIM    = OM_W'((1 << (W - 1)) - 1);
	localparam logic [OM_W-1:0]    NEG_LIM    = OM_W'(1 << (W - 1));

	// config registers
	logic [GAIN_W-1:0] gain_q;
	logic [CEIL_W-1:0] ceil_q;
	logic              clip_en_q;

	// per-word working registers
	logic              neg_i_q, neg_q_q, last_q, clip_q;
	logic [W-1:0]      mag_i_q, mag_q_q;
	logic [SMAG_W-1:0] smag_i_q, smag_q_q;
	logic [P_W-1:0]    p_q;
	logic [SQ_W-1:0]   sq_i_q, sq_q_q;
	logic [CSQ_W-1:0]  ceil_sq_q;
	logic [M2_W-1:0]   m2_q;
	logic [NUM_W-1:0]  num_i_q, num_q_q;

	// square root registers
	logic [N_W-1:0]    n_q;
	logic [SR_W-1:0]   sr_rem_q;
	logic [RT_W-1:0]   root_q;
	logic [D_W-1:0]    d_q;

	// divider registers
	logic [D_W-1:0]    dv_rem_q;
	logic [CEIL_W-1:0] dv_lo_q;
	logic [CEIL_W-1:0] quo_q;
	logic [CEIL_W-1:0] qi_q;

	// block metrics and counters
	logic [ACC_W-1:0]  acc_q;
	logic [PEAK_W-1:0] peak_q;
	logic [CNT_W-1:0]  clip_cnt_q, proc_cnt_q;

	// output register
	logic                out_valid_q;
	logic signed [W-1:0] out_i_q, out_q_q;
	logic                was_clipped_q, last_out_q;
	logic [ACC_W-1:0]    power_sum_q;
	logic [PEAK_W-1:0]   peak_out_q;
	logic [CNT_W-1:0]    tot_clip_q, tot_proc_q;

	logic [SPROD_W-1:0] prod_i, prod_q;
	logic [P_W-1:0]     pw_i, pw_q;
	logic               clip_hit;
	logic [SR_W+1:0]    sr_ext, sr_trial, sr_diff;
	logic               sr_ge;
	logic [NUM_W-1:0]   num_sel;
	logic [D_W:0]       dv_ext, dv_den, dv_diff;
	logic               dv_ge;
	logic [SUM_W-1:0]   acc_sum, p_ext;
	logic [ACC_W-1:0]   acc_new;
	logic [PEAK_W-1:0]  peak_new, p_clamp;
	logic [CNT_W-1:0]   clip_cnt_new, proc_cnt_new;
	logic [OM_W-1:0]    fin_mag_i, fin_mag_q;

	// saturate a sign and magnitude pair to the sample range
	function automatic logic [W-1:0] sat_word(input logic neg, input logic [OM_W-1:0] mag);
		logic [OM_W-1:0] m;
		logic [OM_W-1:0] neg_m;
		if (neg) begin
			m = (mag > NEG_LIM) ? NEG_LIM : mag;
		end else begin
			m = (mag > POS_LIM) ? POS_LIM : mag;
		end
		neg_m = OM_W'(0) - m;
		return neg ? neg_m[W-1:0] : m[W-1:0];
	endfunction

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RESET;
			ceil_q    <= CEIL_RESET;
			clip_en_q <= CLIP_EN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:    gain_q    <= cfg_data;
				REG_CEILING: ceil_q    <= cfg_data[CEIL_W-1:0];
				REG_CLIP_EN: clip_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// gain products with rounding, and input power
	assign prod_i = SPROD_W'(mag_i_q) * SPROD_W'(gain_q) + ROUND_HALF;
	assign prod_q = SPROD_W'(mag_q_q) * SPROD_W'(gain_q) + ROUND_HALF;
	assign pw_i   = P_W'(mag_i_q) * P_W'(mag_i_q);
	assign pw_q   = P_W'(mag_q_q) * P_W'(mag_q_q);

	// magnitude test against the ceiling
	assign clip_hit = clip_en_q && (CMP_W'(m2_q) > CMP_W'(ceil_sq_q));

	// one root bit per step
	assign sr_ext   = {sr_rem_q, n_q[N_W-1 -: 2]};
	assign sr_trial = {2'b00, root_q, 2'b01};
	assign sr_ge    = (sr_ext >= sr_trial);
	assign sr_diff  = sr_ext - sr_trial;

	// one quotient bit per step
	assign num_sel = cmd.div_sel ? num_q_q : num_i_q;
	assign dv_ext  = {dv_rem_q, dv_lo_q[CEIL_W-1]};
	assign dv_den  = {1'b0, d_q};
	assign dv_ge   = (dv_ext >= dv_den);
	assign dv_diff = dv_ext - dv_den;

	// sample path registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_i_q <= sample_i[W-1];
			neg_q_q <= sample_q[W-1];
			mag_i_q <= sample_i[W-1] ? W'(-sample_i) : W'(sample_i);
			mag_q_q <= sample_q[W-1] ? W'(-sample_q) : W'(sample_q);
			last_q  <= block_end;
		end
		if (cmd.scale) begin
			smag_i_q <= prod_i[SPROD_W-1:F];
			smag_q_q <= prod_q[SPROD_W-1:F];
			p_q      <= pw_i + pw_q;
		end
		if (cmd.square) begin
			sq_i_q    <= SQ_W'(smag_i_q) * SQ_W'(smag_i_q);
			sq_q_q    <= SQ_W'(smag_q_q) * SQ_W'(smag_q_q);
			ceil_sq_q <= CSQ_W'(ceil_q) * CSQ_W'(ceil_q);
		end
		if (cmd.mag) begin
			m2_q <= M2_W'(sq_i_q) + M2_W'(sq_q_q);
		end
		if (cmd.decide) begin
			clip_q <= clip_hit;
		end
		if (cmd.prod) begin
			num_i_q <= NUM_W'(smag_i_q) * NUM_W'(ceil_q);
			num_q_q <= NUM_W'(smag_q_q) * NUM_W'(ceil_q);
		end
	end

	// square root, rounded up at the end
	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			n_q      <= N_W'(m2_q);
			sr_rem_q <= '0;
			root_q   <= '0;
		end else if (cmd.sqrt_step) begin
			n_q      <= n_q << 2;
			sr_rem_q <= sr_ge ? sr_diff[SR_W-1:0] : sr_ext[SR_W-1:0];
			root_q   <= {root_q[RT_W-2:0], sr_ge};
		end
		if (cmd.round) begin
			d_q <= D_W'(root_q) + D_W'(sr_rem_q != '0);
		end
	end

	// shared divider; the high part of the numerator is already below the divisor
	always_ff @(posedge clk) begin
		if (cmd.div_keep) begin
			qi_q <= quo_q;
		end
		if (cmd.div_load) begin
			dv_rem_q <= D_W'(num_sel[NUM_W-1:CEIL_W]);
			dv_lo_q  <= num_sel[CEIL_W-1:0];
		end else if (cmd.div_step) begin
			dv_rem_q <= dv_ge ? dv_diff[D_W-1:0] : dv_ext[D_W-1:0];
			dv_lo_q  <= dv_lo_q << 1;
			quo_q    <= {quo_q[CEIL_W-2:0], dv_ge};
		end
	end

	// block metrics and counters after this word
	assign acc_sum      = SUM_W'(acc_q) + SUM_W'(p_q);
	assign acc_new      = (acc_sum > SUM_W'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
	assign p_ext        = SUM_W'(p_q);
	assign p_clamp      = (p_ext > SUM_W'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(p_ext);
	assign peak_new     = (p_ext > SUM_W'(peak_q)) ? p_clamp : peak_q;
	assign clip_cnt_new = (clip_q && (clip_cnt_q != CNT_MAX)) ? clip_cnt_q + 1'b1 : clip_cnt_q;
	assign proc_cnt_new = (clip_en_q && (proc_cnt_q != CNT_MAX)) ?
	                      proc_cnt_q + 1'b1 : proc_cnt_q;

	// clipped or plain magnitudes
	assign fin_mag_i = clip_q ? OM_W'(qi_q) : OM_W'(smag_i_q);
	assign fin_mag_q = clip_q ? OM_W'(quo_q) : OM_W'(smag_q_q);

	// metric state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			peak_q      <= '0;
			clip_cnt_q  <= '0;
			proc_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				acc_q      <= last_q ? '0 : acc_new;
				peak_q     <= last_q ? '0 : peak_new;
				clip_cnt_q <= clip_cnt_new;
				proc_cnt_q <= proc_cnt_new;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_i_q       <= sat_word(neg_i_q, fin_mag_i);
			out_q_q       <= sat_word(neg_q_q, fin_mag_q);
			was_clipped_q <= clip_q;
			last_out_q    <= last_q;
			power_sum_q   <= last_q ? acc_new : '0;
			peak_out_q    <= last_q ? peak_new : '0;
			tot_clip_q    <= clip_cnt_new;
			tot_proc_q    <= proc_cnt_new;
		end
	end

	assign sts.clip_hit = clip_hit;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign out_i            = out_i_q;
	assign out_q            = out_q_q;
	assign was_clipped      = was_clipped_q;
	assign last_out         = last_out_q;
	assign block_power_sum  = power_sum_q;
	assign block_peak_power = peak_out_q;
	assign total_clipped    = tot_clip_q;
	assign total_processed  = tot_proc_q;

endmodule

`default_nettype wire

// ===== rtl/gain_and_magnitude_clipper.sv =====
// Top level of the gain and magnitude clipper: joins gmc_ctrl and gmc_dp.
// Depends on gmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Scales complex samples by an unsigned Q4.12 gain and, with clipping on,
// pulls any sample whose magnitude exceeds the ceiling back onto it with
// the phase kept; reports per-block power sum and peak with the last word,
// plus saturating clip and processed-word counts; words count as processed
// only while clipping is on. One word is worked on at a time: a word that
// is not clipped goes from accept through scale, square, magnitude and the
// ceiling decision into the output register; a clipped word also passes
// the bit-serial square root, whose bit count is R = SAMPLE_WIDTH + 18 -
// GAIN_FRAC_BITS (R is 22 at the default format), its rounding step, and
// two divisions with 15-bit quotients, one per component, which share one
// divider. A stalled output holds back the finish of the word behind it.
// The output register holds a finished word while the next input word is
// accepted. No clearing pass after reset.
module gain_and_magnitude_clipper #(
	parameter int SAMPLE_WIDTH   = gmc_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = gmc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gmc_pkg::GAIN_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_q,
	input  wire logic                          block_end,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]     out_i,
	output logic signed [SAMPLE_WIDTH-1:0]     out_q,
	output logic                               was_clipped,
	output logic                               last_out,
	output logic [gmc_pkg::ACC_W-1:0]          block_power_sum,
	output logic [gmc_pkg::PEAK_W-1:0]         block_peak_power,
	output logic [gmc_pkg::CNT_W-1:0]          total_clipped,
	output logic [gmc_pkg::CNT_W-1:0]          total_processed
);
	import gmc_pkg::*;

	gmc_cmd_t cmd;
	gmc_sts_t sts;

	// sequencer
	gmc_ctrl #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	gmc_dp #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.sample_i         (sample_i),
		.sample_q         (sample_q),
		.block_end        (block_end),
		.out_stall        (out_stall),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.out_i            (out_i),
		.out_q            (out_q),
		.was_clipped      (was_clipped),
		.last_out         (last_out),
		.block_power_sum  (block_power_sum),
		.block_peak_power (block_peak_power),
		.total_clipped    (total_clipped),
		.total_processed  (total_processed)
	);

endmodule

`default_nettype wire

// ===== rtl/gmc_checker.sv =====
// Port-level checks for the gain and magnitude clipper, bound to the top level.
// Depends on gmc_pkg and gain_and_magnitude_clipper.
`timescale 1ns / 1ps
`default_nettype none

module gmc_checker #(
	parameter int SAMPLE_WIDTH = gmc_pkg::SAMPLE_WIDTH_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic signed [SAMPLE_WIDTH-1:0] out_i,
	input wire logic signed [SAMPLE_WIDTH-1:0] out_q,
	input wire logic                           last_out,
	input wire logic [gmc_pkg::ACC_W-1:0]      block_power_sum,
	input wire logic [gmc_pkg::PEAK_W-1:0]     block_peak_power,
	input wire logic [gmc_pkg::CNT_W-1:0]      total_clipped,
	input wire logic [gmc_pkg::CNT_W-1:0]      total_processed
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_i) && $stable(out_q))
		else $error("output word changed while stalled");

	// block metrics only show on the last word of a block
	a_metrics_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_out |-> block_power_sum == '0 && block_peak_power == '0)
		else $error("block metrics on a word that is not last");

	// clipped words are a subset of processed words
	a_clip_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_clipped <= total_processed)
		else $error("clip count above processed count");

	// one word in flight: an accepted word closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a word is in flight");

endmodule

bind gain_and_magnitude_clipper gmc_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.out_i            (out_i),
	.out_q            (out_q),
	.last_out         (last_out),
	.block_power_sum  (block_power_sum),
	.block_peak_power (block_peak_power),
	.total_clipped    (total_clipped),
	.total_processed  (total_processed)
);

`default_nettype wire

// ===== bench/gmc_checker.sv =====
// Checker for the gain and magnitude clipper: watches the register port and both
// word channels, predicts every output word and compares it field by field.
// Depends on gmc_pkg.
`timescale 1ns / 1ps

module gmc_bench_checker
	import gmc_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  gmc_reg_t                        cfg_index,
	input  logic [GAIN_W-1:0]               cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] sample_i,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] sample_q,
	input  logic                            block_end,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] out_i,
	input  logic signed [SAMPLE_WIDTH_DEF-1:0] out_q,
	input  logic                            was_clipped,
	input  logic                            last_out,
	input  logic [ACC_W-1:0]                block_power_sum,
	input  logic [PEAK_W-1:0]               block_peak_power,
	input  logic [CNT_W-1:0]                total_clipped,
	input  logic [CNT_W-1:0]                total_processed,
	output int                              fail_count,
	output int                              words_pending
);

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int GF = GAIN_FRAC_BITS_DEF;
	localparam longint ACC_MAX = (64'sd1 <<< ACC_W) - 1;
	localparam longint CNT_MAX = (64'sd1 <<< CNT_W) - 1;
	localparam longint SMP_MAX = (64'sd1 <<< (SW - 1)) - 1;
	localparam longint SMP_MIN = -(64'sd1 <<< (SW - 1));

	typedef struct packed {
		logic signed [SW-1:0] i;
		logic signed [SW-1:0] q;
		logic                 clipped;
		logic                 last;
		logic [ACC_W-1:0]     psum;
		logic [PEAK_W-1:0]    peak;
		logic [CNT_W-1:0]     nclip;
		logic [CNT_W-1:0]     nproc;
	} gmc_word_t;

	// register copies
	logic [GAIN_W-1:0] gain_reg;
	logic [CEIL_W-1:0] ceil_reg;
	logic              clip_on;

	// block metrics and running counts
	longint power_acc;
	longint peak_pow;
	longint clip_cnt;
	longint proc_cnt;

	gmc_word_t words_due[$];
	gmc_word_t want;
	int        word_no;

	initial fail_count = 0;
	initial words_pending = 0;

	// gain with rounding half away from zero
	function automatic longint scale_comp(longint x);
		longint m;
		m = ((x < 0 ? -x : x) * longint'(gain_reg) + (64'sd1 <<< (GF - 1))) >>> GF;
		return x < 0 ? -m : m;
	endfunction

	// smallest r with r*r >= n
	function automatic longint ceil_root(longint n);
		longint r;
		longint t;
		int     b;
		r = 0;
		for (b = 21; b >= 0; b--) begin
			t = r | (64'sd1 <<< b);
			if (t * t <= n)
				r = t;
		end
		if (r * r < n)
			r++;
		return r;
	endfunction

	// pull one component onto the ceiling, truncating toward zero
	function automatic longint shrink(longint s, longint d);
		longint m;
		m = ((s < 0 ? -s : s) * longint'(ceil_reg)) / d;
		return s < 0 ? -m : m;
	endfunction

	function automatic logic signed [SW-1:0] saturate(longint v);
		if (v > SMP_MAX)
			return SW'(SMP_MAX);
		if (v < SMP_MIN)
			return SW'(SMP_MIN);
		return SW'(v);
	endfunction

	// expected output word for one input word; advances the metrics and counts
	function automatic gmc_word_t scale_and_clip(longint xi, longint xq, logic last);
		gmc_word_t w;
		longint    p;
		longint    si;
		longint    sq;
		longint    m2;
		longint    d;
		logic      hit;
		p = xi * xi + xq * xq;
		power_acc = (power_acc + p > ACC_MAX) ? ACC_MAX : power_acc + p;
		if (p > peak_pow)
			peak_pow = p;
		si = scale_comp(xi);
		sq = scale_comp(xq);
		hit = 1'b0;
		if (clip_on) begin
			m2 = si * si + sq * sq;
			if (m2 > longint'(ceil_reg) * longint'(ceil_reg)) begin
				d = ceil_root(m2);
				si = shrink(si, d);
				sq = shrink(sq, d);
				hit = 1'b1;
				if (clip_cnt < CNT_MAX)
					clip_cnt++;
			end
			if (proc_cnt < CNT_MAX)
				proc_cnt++;
		end
		w.i = saturate(si);
		w.q = saturate(sq);
		w.clipped = hit;
		w.last = last;
		w.psum = last ? ACC_W'(power_acc) : '0;
		w.peak = last ? PEAK_W'(peak_pow) : '0;
		w.nclip = CNT_W'(clip_cnt);
		w.nproc = CNT_W'(proc_cnt);
		if (last) begin
			power_acc = 0;
			peak_pow = 0;
		end
		return w;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] exp_val);
		if (fail_count < 40)
			$display("word %0d: %s got %0h want %0h", word_no, what, got, exp_val);
		fail_count++;
	endtask

	task automatic compare(string what, logic [63:0] got, logic [63:0] exp_val);
		if (got !== exp_val)
			report(what, got, exp_val);
	endtask

	// follow register writes, predict accepted words, check delivered words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_reg = GAIN_RESET;
			ceil_reg = CEIL_RESET;
			clip_on = CLIP_EN_RESET;
			power_acc = 0;
			peak_pow = 0;
			clip_cnt = 0;
			proc_cnt = 0;
			word_no = 0;
			words_due.delete();
			words_pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN: gain_reg = cfg_data;
					REG_CEILING: ceil_reg = cfg_data[CEIL_W-1:0];
					REG_CLIP_EN: clip_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				words_due.push_back(scale_and_clip(longint'(sample_i), longint'(sample_q),
					block_end));
			if (out_valid && !out_stall) begin
				if (words_due.size() == 0) begin
					report("word with none expected, out_i", 64'(out_i), '0);
				end else begin
					want = words_due.pop_front();
					compare("out_i", 64'(out_i), 64'(want.i));
					compare("out_q", 64'(out_q), 64'(want.q));
					compare("was_clipped", 64'(was_clipped), 64'(want.clipped));
					compare("last_out", 64'(last_out), 64'(want.last));
					compare("block_power_sum", 64'(block_power_sum), 64'(want.psum));
					compare("block_peak_power", 64'(block_peak_power), 64'(want.peak));
					compare("total_clipped", 64'(total_clipped), 64'(want.nclip));
					compare("total_processed", 64'(total_processed), 64'(want.nproc));
				end
				word_no++;
			end
			words_pending = words_due.size();
		end
	end

endmodule

// ===== bench/tb_gain_and_magnitude_clipper.sv =====
// Top of the gain and magnitude clipper bench: clock, reset, register writes,
// sample stimulus with idle and stall phases, and the verdict.
// Depends on gmc_pkg, gmc_bench_checker and the block itself.
`timescale 1ns / 1ps

module tb_gain_and_magnitude_clipper;
	import gmc_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_WORDS = 106;
	localparam int LONG_BLOCK = 16;
	localparam logic signed [SW-1:0] S_MAX = 16'h7fff;
	localparam logic signed [SW-1:0] S_MIN = 16'h8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	gmc_reg_t cfg_index = REG_GAIN;
	logic [GAIN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample_i = '0;
	logic signed [SW-1:0] sample_q = '0;
	logic block_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] out_i;
	logic signed [SW-1:0] out_q;
	logic was_clipped;
	logic last_out;
	logic [ACC_W-1:0] block_power_sum;
	logic [PEAK_W-1:0] block_peak_power;
	logic [CNT_W-1:0] total_clipped;
	logic [CNT_W-1:0] total_processed;

	int fail_count;
	int words_pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	gain_and_magnitude_clipper dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_i        (sample_i),
		.sample_q        (sample_q),
		.block_end       (block_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_i           (out_i),
		.out_q           (out_q),
		.was_clipped     (was_clipped),
		.last_out        (last_out),
		.block_power_sum (block_power_sum),
		.block_peak_power(block_peak_power),
		.total_clipped   (total_clipped),
		.total_processed (total_processed)
	);

	gmc_bench_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_i        (sample_i),
		.sample_q        (sample_q),
		.block_end       (block_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_i           (out_i),
		.out_q           (out_q),
		.was_clipped     (was_clipped),
		.last_out        (last_out),
		.block_power_sum (block_power_sum),
		.block_peak_power(block_peak_power),
		.total_clipped   (total_clipped),
		.total_processed (total_processed),
		.fail_count      (fail_count),
		.words_pending   (words_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly full-range values, with extremes, zero and small values mixed in
	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return SW'($urandom_range(127)) - SW'(64);
			default: return SW'($urandom);
		endcase
	endfunction

	// one word, after a random gap; valid stays high while stalled
	task automatic send_word(logic signed [SW-1:0] si, logic signed [SW-1:0] sq, logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_i <= si;
		sample_q <= sq;
		block_end <= last;
		@(posedge clk iff !in_stall);
	endtask

	// wait until every expected word has come out and the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk iff (words_pending == 0));
		repeat (8) @(posedge clk);
	endtask

	// write all three registers back to back
	task automatic set_config(logic [GAIN_W-1:0] g, logic [CEIL_W-1:0] c, logic en);
		cfg_we <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_CEILING;
		cfg_data <= GAIN_W'(c);
		@(posedge clk);
		cfg_index <= REG_CLIP_EN;
		cfg_data <= GAIN_W'(en);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int ph;
		int sent;
		int blen;
		int k;
		logic [GAIN_W-1:0] g;
		logic [CEIL_W-1:0] c;
		logic en;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full-scale words clip onto the top of the range
		send_word(S_MAX, S_MAX, 1'b0);
		send_word(S_MIN, S_MIN, 1'b0);
		send_word(S_MIN, '0, 1'b0);
		send_word('0, '0, 1'b1);
		send_word(16'sd1, -16'sd1, 1'b0);
		send_word(S_MAX, '0, 1'b1);

		// zero ceiling with maximum gain: any nonzero word collapses to zero
		drain();
		set_config(16'hffff, '0, 1'b1);
		send_word(16'sd1, '0, 1'b0);
		send_word('0, '0, 1'b0);
		send_word(S_MIN, S_MAX, 1'b1);

		// clipping off: outputs saturate, counts hold
		drain();
		set_config(16'hffff, 15'h7fff, 1'b0);
		send_word(S_MAX, S_MIN, 1'b0);
		send_word(16'sd100, -16'sd100, 1'b0);
		send_word(16'sd3000, -16'sd3000, 1'b1);

		// zero gain
		drain();
		set_config('0, 15'd1000, 1'b1);
		send_word(16'sd12345, -16'sd12345, 1'b1);

		// magnitude right at the ceiling is kept, just above is clipped
		drain();
		set_config(16'd4096, 15'd20000, 1'b1);
		send_word(16'sd20000, '0, 1'b0);
		send_word(16'sd20000, 16'sd1, 1'b0);
		send_word(-16'sd15000, -16'sd15000, 1'b1);

		// gain of 1.5 on odd values: halves round away from zero
		drain();
		set_config(16'd6144, 15'h7fff, 1'b1);
		send_word(16'sd1, -16'sd1, 1'b0);
		send_word(16'sd3, -16'sd3, 1'b1);

		// long block at full power builds a large power sum
		drain();
		set_config(16'd4096, 15'h7fff, 1'b0);
		for (k = 0; k < LONG_BLOCK; k++)
			send_word(S_MIN, S_MIN, k == LONG_BLOCK - 1);

		// random blocks under random settings, through each idle and stall mix
		for (ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 79; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 79; end
				default: begin idle_pct = 23; stall_pct = 23; end
			endcase
			case ($urandom_range(4))
				0: g = '0;
				1: g = 16'hffff;
				2: g = 16'd4096;
				3: g = GAIN_W'($urandom_range(8192, 2048));
				default: g = GAIN_W'($urandom);
			endcase
			case ($urandom_range(3))
				0: c = '0;
				1: c = 15'h7fff;
				default: c = CEIL_W'($urandom);
			endcase
			en = ($urandom_range(3) != 0);
			set_config(g, c, en);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				blen = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
				if (blen > PHASE_WORDS - sent)
					blen = PHASE_WORDS - sent;
				for (k = 0; k < blen; k++)
					send_word(rand_sample(), rand_sample(), k == blen - 1);
				sent += blen;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
